>>> src/plc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_pkg
// Shared types and constants for the pattern lock controller.
// ----------------------------------------------------------------------------
package plc_pkg;

    localparam int OPCODE_W   = 2;
    localparam int DOT_W      = 8;
    localparam int MODE_W     = 3;
    localparam int FAIL_W     = 8;
    localparam int LIMIT_W    = 8;
    localparam int MIN_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOCKED      = 3'd0,
        MODE_UNLOCKED    = 3'd1,
        MODE_LOCKOUT     = 3'd2,
        MODE_REGISTERING = 3'd3,
        MODE_CONFIRMING  = 3'd4
    } t_mode;

    typedef enum logic [OPCODE_W-1:0] {
        OP_DOT      = 2'd0,
        OP_SET_MODE = 2'd1,
        OP_REINIT   = 2'd2,
        OP_NOP      = 2'd3
    } t_opcode;

    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ENROLL    = 2'd1;

    localparam logic [LIMIT_W-1:0] LOCKOUT_LIMIT_RST = 8'd5;
    localparam logic [MIN_W-1:0]   MIN_ENROLL_RST    = 4'd4;
    localparam logic [FAIL_W-1:0]  FAIL_MAX          = 8'd255;

    localparam int INIT_LEN = 5;
    localparam logic [DOT_W-1:0] INIT_PATTERN [INIT_LEN] = '{8'd0, 8'd1, 8'd2, 8'd5, 8'd8};

endpackage

>>> src/plc_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_ifs
// Valid/ready channel interfaces: dot input, result output, config writes.
// ----------------------------------------------------------------------------
interface plc_in_if
    import plc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [DOT_W-1:0]    dot;
    logic                last_dot;
    logic [MODE_W-1:0]   new_mode;

    modport source (output valid, opcode, dot, last_dot, new_mode, input ready);
    modport sink   (input valid, opcode, dot, last_dot, new_mode, output ready);
endinterface

interface plc_out_if
    import plc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              accepted;
    logic [MODE_W-1:0] mode;
    logic [FAIL_W-1:0] failure_count;
    logic              length_error;

    modport source (output valid, accepted, mode, failure_count, length_error, input ready);
    modport sink   (input valid, accepted, mode, failure_count, length_error, output ready);
endinterface

interface plc_cfg_if
    import plc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/plc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_cfg_regs
// Configuration register file: lockout limit and minimum enroll length.
// ----------------------------------------------------------------------------
module plc_cfg_regs
    import plc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    plc_cfg_if.sink            i_cfg,
    output logic [LIMIT_W-1:0] o_lockout_limit,
    output logic [MIN_W-1:0]   o_min_enroll
);

    logic [LIMIT_W-1:0] r_lockout_limit;
    logic [MIN_W-1:0]   r_min_enroll;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lockout_limit <= LOCKOUT_LIMIT_RST;
            r_min_enroll    <= MIN_ENROLL_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_LOCKOUT_LIMIT: r_lockout_limit <= i_cfg.data[LIMIT_W-1:0];
                CFG_MIN_ENROLL:    r_min_enroll    <= i_cfg.data[MIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_lockout_limit = r_lockout_limit;
    assign o_min_enroll    = r_min_enroll;

endmodule

>>> src/plc_bank_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_bank_mem
// Two pattern banks, one write and one registered read per cycle. Bank 0
// reads the factory pattern until an entry is overwritten.
// ----------------------------------------------------------------------------
module plc_bank_mem
    import plc_pkg::*;
#(
    parameter int MAX_DOTS = 9,
    parameter int DOT_BITS = 8,
    localparam int IDX_W   = $clog2(MAX_DOTS),
    localparam int INIT_N  = (MAX_DOTS < INIT_LEN) ? MAX_DOTS : INIT_LEN
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_en,
    input  logic                i_wr_bank,
    input  logic [IDX_W-1:0]    i_wr_idx,
    input  logic [DOT_BITS-1:0] i_wr_data,
    input  logic                i_rd_bank,
    input  logic [IDX_W-1:0]    i_rd_idx,
    output logic [DOT_BITS-1:0] o_rd_data
);

    logic [DOT_BITS-1:0] mem [2][MAX_DOTS];
    logic [INIT_N-1:0]   r_init_vld;
    logic [DOT_BITS-1:0] r_rd_data;
    logic                init_hit;
    logic [DOT_BITS-1:0] init_val;

    always_comb begin
        init_hit = 1'b0;
        init_val = '0;
        for (int i = 0; i < INIT_N; i++) begin
            if (!i_rd_bank && i_rd_idx == IDX_W'(i) && r_init_vld[i]) begin
                init_hit = 1'b1;
                init_val = INIT_PATTERN[i][DOT_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_vld <= '1;
        end else begin
            for (int i = 0; i < INIT_N; i++) begin
                if (i_wr_en && !i_wr_bank && i_wr_idx == IDX_W'(i)) begin
                    r_init_vld[i] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_bank][i_wr_idx] <= i_wr_data;
        end
        // write-first on a same-address collision
        if (i_wr_en && i_wr_bank == i_rd_bank && i_wr_idx == i_rd_idx) begin
            r_rd_data <= i_wr_data;
        end else if (init_hit) begin
            r_rd_data <= init_val;
        end else begin
            r_rd_data <= mem[i_rd_bank][i_rd_idx];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/pattern_lock_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pattern_lock_controller_top
// Pattern lock: per-dot compare or capture, decision on the last dot.
// Latency: a result is valid the cycle after its final item is accepted.
// Throughput: one item per cycle unless a pending result is held by o_out.ready;
//   the bank read for the next dot is prefetched from next-state position.
// Reset: synchronous active low; locked, zero failures, factory pattern
//   in bank 0, config registers to their defaults. No clearing pass.
// ----------------------------------------------------------------------------
module pattern_lock_controller_top
    import plc_pkg::*;
#(
    parameter int MAX_DOTS = 9,
    parameter int DOT_BITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    plc_in_if.sink    i_in,
    plc_out_if.source o_out,
    plc_cfg_if.sink   i_cfg
);

    localparam int POS_W = $clog2(MAX_DOTS + 1);
    localparam int IDX_W = $clog2(MAX_DOTS);
    localparam logic [POS_W-1:0] POS_MAX  = POS_W'(MAX_DOTS);
    localparam logic [POS_W-1:0] INIT_LEN_P = POS_W'(INIT_LEN);

    logic [LIMIT_W-1:0] lockout_limit;
    logic [MIN_W-1:0]   min_enroll;

    // lock state
    t_mode              r_mode,     n_mode;
    logic [FAIL_W-1:0]  r_failures, n_failures;
    logic [POS_W-1:0]   r_len_a,    n_len_a;
    logic [POS_W-1:0]   r_len_b,    n_len_b;
    logic               r_sel,      n_sel;
    logic [POS_W-1:0]   r_pos,      n_pos;
    logic               r_mismatch, n_mismatch;
    logic               r_overflow, n_overflow;

    // result register
    logic               r_out_valid;
    logic               r_out_acc;
    t_mode              r_out_mode;
    logic [FAIL_W-1:0]  r_out_fail;
    logic               r_out_lerr;

    logic                take;
    logic                emit;
    logic                acc;
    logic                lerr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_idx;
    logic [DOT_BITS-1:0] dot_in;
    logic [DOT_BITS-1:0] rd_dot;
    logic                rd_bank;
    logic [IDX_W-1:0]    rd_idx;
    logic                held;
    logic [POS_W-1:0]    stored_len;
    logic [POS_W-1:0]    held_len;
    logic [POS_W-1:0]    ref_len;
    logic                in_range;
    logic                ovf;
    logic                mism;
    logic [POS_W-1:0]    pos1;
    logic [FAIL_W-1:0]   fail_inc;

    plc_cfg_regs u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (i_cfg),
        .o_lockout_limit (lockout_limit),
        .o_min_enroll    (min_enroll)
    );

    plc_bank_mem #(
        .MAX_DOTS (MAX_DOTS),
        .DOT_BITS (DOT_BITS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_bank (held),
        .i_wr_idx  (wr_idx),
        .i_wr_data (dot_in),
        .i_rd_bank (rd_bank),
        .i_rd_idx  (rd_idx),
        .o_rd_data (rd_dot)
    );

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign take       = i_in.valid && i_in.ready;

    assign held       = ~r_sel;
    assign stored_len = r_sel ? r_len_b : r_len_a;
    assign held_len   = r_sel ? r_len_a : r_len_b;
    assign ref_len    = (r_mode == MODE_CONFIRMING) ? held_len : stored_len;
    assign dot_in     = i_in.dot[DOT_BITS-1:0];
    assign in_range   = r_pos < POS_MAX;
    assign pos1       = in_range ? r_pos + POS_W'(1) : r_pos;
    assign wr_idx     = in_range ? r_pos[IDX_W-1:0] : '0;
    assign fail_inc   = (r_failures < FAIL_MAX) ? r_failures + FAIL_W'(1) : r_failures;

    always_comb begin
        n_mode     = r_mode;
        n_failures = r_failures;
        n_len_a    = r_len_a;
        n_len_b    = r_len_b;
        n_sel      = r_sel;
        n_pos      = r_pos;
        n_mismatch = r_mismatch;
        n_overflow = r_overflow;
        emit       = 1'b0;
        acc        = 1'b0;
        lerr       = 1'b0;
        wr_en      = 1'b0;
        ovf        = r_overflow || !in_range;
        mism       = r_mismatch;
        if (in_range && r_mode != MODE_REGISTERING &&
            (r_pos >= ref_len || rd_dot != dot_in)) begin
            mism = 1'b1;
        end

        if (take) begin
            case (t_opcode'(i_in.opcode))
                OP_SET_MODE: begin
                    if (i_in.new_mode <= MODE_CONFIRMING) begin
                        n_mode = t_mode'(i_in.new_mode);
                    end
                    n_pos      = '0;
                    n_mismatch = 1'b0;
                    n_overflow = 1'b0;
                    emit       = 1'b1;
                end
                OP_REINIT: begin
                    n_mode     = MODE_LOCKED;
                    n_failures = '0;
                    n_pos      = '0;
                    n_mismatch = 1'b0;
                    n_overflow = 1'b0;
                    emit       = 1'b1;
                end
                OP_DOT: begin
                    wr_en = in_range && r_mode == MODE_REGISTERING;
                    if (!i_in.last_dot) begin
                        n_pos      = pos1;
                        n_mismatch = mism;
                        n_overflow = ovf;
                    end else begin
                        emit       = 1'b1;
                        n_pos      = '0;
                        n_mismatch = 1'b0;
                        n_overflow = 1'b0;
                        if (ovf) begin
                            lerr = 1'b1;
                            if (r_mode == MODE_REGISTERING) begin
                                if (held) n_len_b = '0;
                                else      n_len_a = '0;
                            end
                        end else begin
                            case (r_mode)
                                MODE_LOCKED: begin
                                    if (!mism && pos1 == stored_len) begin
                                        n_mode     = MODE_UNLOCKED;
                                        n_failures = '0;
                                        acc        = 1'b1;
                                    end else begin
                                        n_failures = fail_inc;
                                        n_mode     = (fail_inc >= lockout_limit) ?
                                                     MODE_LOCKOUT : MODE_LOCKED;
                                    end
                                end
                                MODE_REGISTERING: begin
                                    if (32'(pos1) >= 32'(min_enroll)) begin
                                        if (held) n_len_b = pos1;
                                        else      n_len_a = pos1;
                                        n_mode = MODE_CONFIRMING;
                                        acc    = 1'b1;
                                    end else begin
                                        if (held) n_len_b = '0;
                                        else      n_len_a = '0;
                                    end
                                end
                                MODE_CONFIRMING: begin
                                    if (!mism && pos1 == held_len) begin
                                        n_sel  = held;
                                        n_mode = MODE_LOCKED;
                                        acc    = 1'b1;
                                    end else begin
                                        n_mode = MODE_REGISTERING;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // prefetch the element the next dot compares against
    always_comb begin
        if (!i_rst_n) begin
            rd_bank = 1'b0;
            rd_idx  = '0;
        end else begin
            rd_bank = (n_mode == MODE_CONFIRMING) ? ~n_sel : n_sel;
            rd_idx  = (n_pos < POS_MAX) ? n_pos[IDX_W-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_LOCKED;
            r_failures  <= '0;
            r_len_a     <= INIT_LEN_P;
            r_len_b     <= '0;
            r_sel       <= 1'b0;
            r_pos       <= '0;
            r_mismatch  <= 1'b0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode     <= n_mode;
            r_failures <= n_failures;
            r_len_a    <= n_len_a;
            r_len_b    <= n_len_b;
            r_sel      <= n_sel;
            r_pos      <= n_pos;
            r_mismatch <= n_mismatch;
            r_overflow <= n_overflow;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_acc  <= acc;
            r_out_mode <= n_mode;
            r_out_fail <= n_failures;
            r_out_lerr <= lerr;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.accepted      = r_out_acc;
    assign o_out.mode          = r_out_mode;
    assign o_out.failure_count = r_out_fail;
    assign o_out.length_error  = r_out_lerr;

endmodule
